@@ rtl/half_float_natural_log_core_macros.svh @@
`ifndef HALF_FLOAT_NATURAL_LOG_CORE_MACROS_SVH
`define HALF_FLOAT_NATURAL_LOG_CORE_MACROS_SVH

// ante true at an edge, cons true at the next edge
`define HFNL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// ante true at an edge, cons true at the same edge
`define HFNL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// sig low at the edge after a reset edge
`define HFNL_ASSERT_RST(lbl, sig, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> !(sig)) else $error(msg);

`endif

@@ rtl/hfnl_pkg.sv @@
`default_nettype none
package hfnl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 18;
    localparam int COEF_W        = 18;
    localparam int LN_TWO_W      = 17;
    localparam int HALF_W        = 16;
    localparam int HALF_MAN_W    = 10;
    localparam int HALF_EXP_W    = 5;
    localparam int EXP_BIAS      = 15;
    // largest leading-zero count of the fixed-point magnitude with a normal result
    localparam int LZ_NORM_MAX   = 20;
    localparam int SUB_ALIGN     = 24;

    localparam logic [HALF_EXP_W-1:0] EXP_ALL_ONES = 5'h1F;
    localparam logic [HALF_W-1:0] HALF_NEG_INF = 16'hFC00;
    localparam logic [HALF_W-1:0] HALF_POS_INF = 16'h7C00;
    localparam logic [HALF_W-1:0] HALF_QNAN    = 16'h7E00;

    localparam logic signed [COEF_W-1:0] COEF_ONE_RST   = 18'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_TWO_RST   = -18'sd32768;
    localparam logic signed [COEF_W-1:0] COEF_THREE_RST = 18'sd21845;
    localparam logic signed [COEF_W-1:0] COEF_FOUR_RST  = -18'sd16384;
    localparam logic [LN_TWO_W-1:0]      LN_TWO_RST     = 17'd45426;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY_MODE  = 3'd0,
        CFG_COEF_ONE   = 3'd1,
        CFG_COEF_TWO   = 3'd2,
        CFG_COEF_THREE = 3'd3,
        CFG_COEF_FOUR  = 3'd4,
        CFG_LN_TWO     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PM_HORNER = 2'd0,
        PM_QUAD   = 2'd1,
        PM_LINEAR = 2'd2
    } t_poly_mode;

    typedef struct packed {
        logic [HALF_W-1:0] x_bits;
        logic              last_in;
    } t_in_beat;

    typedef struct packed {
        logic [HALF_W-1:0] log_bits;
        logic              special_input;
        logic              last_out;
    } t_out_beat;

    typedef struct packed {
        logic              special;
        logic [HALF_W-1:0] spec_bits;
        logic              last;
    } t_side;

endpackage
`default_nettype wire

@@ rtl/hfnl_to_half.sv @@
`default_nettype none
module hfnl_to_half #(
    parameter int FRAC_BITS = hfnl_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [FRAC_BITS+6:0] i_sum,
    input  hfnl_pkg::t_side          i_side,
    output logic                     o_stall,
    output logic                     o_valid,
    output hfnl_pkg::t_out_beat      o_beat,
    input  logic                     i_stall
);
    import hfnl_pkg::*;

    localparam int SW     = FRAC_BITS + 7;
    localparam int LZW    = $clog2(SW);
    localparam int SUB_SH = SUB_ALIGN - FRAC_BITS;
    localparam int SUBW   = SW + SUB_SH;

    logic           en5, en6;
    logic           neg;
    logic [SW-1:0]  mag;
    logic [SW-1:0]  norm;
    logic [LZW-1:0] lz;

    logic           r_vld5;
    logic [SW-1:0]  r_norm5;
    logic [SW-1:0]  r_mag5;
    logic [LZW-1:0] r_lz5;
    logic           r_neg5;
    logic           r_zero5;
    t_side          r_side5;

    logic [HALF_MAN_W:0]   mant;
    logic                  guard;
    logic                  sticky;
    logic                  rnd;
    logic [HALF_EXP_W-1:0] expo;
    logic [14:0]           norm_mag;
    logic [SUBW-1:0]       sub_w;
    logic [14:0]           half_mag;
    t_out_beat             n_beat;

    logic                  r_vld6;
    t_out_beat             r_beat6;

    assign en6     = !r_vld6 || !i_stall;
    assign en5     = !r_vld5 || en6;
    assign o_stall = !en5;
    assign o_valid = r_vld6;
    assign o_beat  = r_beat6;

    // magnitude and normalize
    assign neg = i_sum[SW-1];
    assign mag = neg ? SW'(-i_sum) : SW'(i_sum);

    always_comb begin
        norm = mag;
        lz   = '0;
        for (int k = LZW - 1; k >= 0; k--) begin
            if ((norm >> (SW - (1 << k))) == '0) begin
                norm = norm << (1 << k);
                lz   = lz | LZW'(1 << k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (en5) begin
            r_vld5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_norm5 <= norm;
            r_mag5  <= mag;
            r_lz5   <= lz;
            r_neg5  <= neg;
            r_zero5 <= (mag == '0);
            r_side5 <= i_side;
        end
    end

    // round to nearest even and pack
    assign mant     = r_norm5[SW-1 -: HALF_MAN_W+1];
    assign guard    = r_norm5[SW-HALF_MAN_W-2];
    assign sticky   = |r_norm5[SW-HALF_MAN_W-3:0];
    assign rnd      = guard && (sticky || mant[0]);
    assign expo     = HALF_EXP_W'(LZ_NORM_MAX) - HALF_EXP_W'(r_lz5);
    assign norm_mag = 15'(mant) + 15'(rnd) + {expo, {HALF_MAN_W{1'b0}}};
    assign sub_w    = SUBW'(r_mag5) << SUB_SH;

    always_comb begin
        if (r_zero5) begin
            half_mag = '0;
        end else if (int'(r_lz5) <= LZ_NORM_MAX) begin
            half_mag = norm_mag;
        end else begin
            half_mag = 15'(sub_w[HALF_MAN_W-1:0]);
        end
        n_beat.special_input = r_side5.special;
        n_beat.last_out      = r_side5.last;
        if (r_side5.special) begin
            n_beat.log_bits = r_side5.spec_bits;
        end else begin
            n_beat.log_bits = {r_neg5 && !r_zero5, half_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
        end else if (en6) begin
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_beat6 <= n_beat;
        end
    end

endmodule
`default_nettype wire

@@ rtl/half_float_natural_log_core.sv @@
// Natural log of one binary16 value per beat, result as binary16.
// Input channel: i_in_valid / o_in_stall carry i_in (x_bits, last_in).
// Output channel: o_out_valid / i_out_stall carry o_out (log_bits,
// special_input, last_out). A beat moves when valid is high and stall low.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high; only while no beat is in flight. Indexes above the list are ignored.
// Pipeline: six register stages, in order three Horner multiply stages,
// a final multiply and add, then normalize and round-and-pack.
// Throughput: one beat per cycle while unstalled; each stage takes a new
// beat if empty or if its successor moves, so bubbles are squeezed out.
// Stall: a stalled output holds its beat; upstream stages keep filling and
// o_in_stall rises only once all six stages hold beats.
// Reset (i_rst_n low at an edge): the pipeline empties and the
// registers return to their defaults (degree-4 polynomial, default
// coefficients, ln 2).
`default_nettype none
module half_float_natural_log_core #(
    parameter int FRAC_BITS = hfnl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hfnl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hfnl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  hfnl_pkg::t_in_beat                i_in,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output hfnl_pkg::t_out_beat               o_out,
    input  logic                              i_out_stall
);
    import hfnl_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int CW     = F + 2;
    localparam int LW     = F + 1;
    localparam int S1W    = F + 3;
    localparam int S2W    = F + 4;
    localparam int S3W    = F + 5;
    localparam int AW     = F + 2;
    localparam int EW     = F + 6;
    localparam int SW     = F + 7;
    localparam int UP_SH  = (F >= 16) ? F - 16 : 0;
    localparam int DN_SH  = (F >= 16) ? 0 : 16 - F;

    logic [1:0]                 r_poly_mode;
    logic signed [COEF_W-1:0]   r_coef_one, r_coef_two, r_coef_three, r_coef_four;
    logic [LN_TWO_W-1:0]        r_ln_two;

    logic signed [CW-1:0] c1q, c2q, c3q, c4q;
    logic [LW-1:0]        lnq;
    logic                 is_quad, is_lin;

    function automatic logic signed [CW-1:0] rescale(input logic signed [COEF_W-1:0] c);
        logic signed [47:0] w;
        w = 48'(c);
        w = (w <<< UP_SH) >>> DN_SH;
        return CW'(w);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_mode  <= PM_HORNER;
            r_coef_one   <= COEF_ONE_RST;
            r_coef_two   <= COEF_TWO_RST;
            r_coef_three <= COEF_THREE_RST;
            r_coef_four  <= COEF_FOUR_RST;
            r_ln_two     <= LN_TWO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLY_MODE:  r_poly_mode  <= i_cfg_data[1:0];
                CFG_COEF_ONE:   r_coef_one   <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_TWO:   r_coef_two   <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_THREE: r_coef_three <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_FOUR:  r_coef_four  <= $signed(i_cfg_data[COEF_W-1:0]);
                CFG_LN_TWO:     r_ln_two     <= i_cfg_data[LN_TWO_W-1:0];
                default: ;
            endcase
        end
    end

    assign c1q     = rescale(r_coef_one);
    assign c2q     = rescale(r_coef_two);
    assign c3q     = rescale(r_coef_three);
    assign c4q     = rescale(r_coef_four);
    assign lnq     = LW'((48'(r_ln_two) << UP_SH) >> DN_SH);
    assign is_quad = (r_poly_mode == PM_QUAD);
    assign is_lin  = (r_poly_mode == PM_LINEAR);

    // stage handshake
    logic en1, en2, en3, en4, th_stall;
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    assign en4        = !r_vld4 || !th_stall;
    assign en3        = !r_vld3 || en4;
    assign en2        = !r_vld2 || en3;
    assign en1        = !r_vld1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_in_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
            if (en3) begin
                r_vld3 <= r_vld2;
            end
            if (en4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    // stage 1: decode, first Horner step, alternate polynomials, exponent term
    logic                    sgn;
    logic [HALF_EXP_W-1:0]   ex;
    logic [HALF_MAN_W-1:0]   man;
    logic [F-1:0]            t;
    logic signed [F:0]       t_s;
    logic signed [2*F+2:0]   m1;
    logic [2*F-1:0]          tt;
    logic [2*F:0]            tl;
    logic [F:0]              quad;
    logic [F:0]              lin;
    logic signed [5:0]       e;
    logic signed [F+7:0]     ep;
    logic signed [S1W-1:0]   n_s1;
    logic signed [AW-1:0]    n_alt;
    t_side                   n_side;

    assign sgn  = i_in.x_bits[HALF_W-1];
    assign ex   = i_in.x_bits[HALF_W-2 -: HALF_EXP_W];
    assign man  = i_in.x_bits[HALF_MAN_W-1:0];
    assign t    = {man, {(F-HALF_MAN_W){1'b0}}};
    assign t_s  = $signed({1'b0, t});
    assign m1   = c4q * t_s;
    assign n_s1 = S1W'(m1 >>> F) + S1W'(c3q);
    assign tt   = t * t;
    assign quad = {1'b0, t} - (F+1)'(tt >> (F + 1));
    assign tl   = t * lnq;
    assign lin  = (F+1)'(tl >> F);
    assign n_alt = is_lin ? AW'(lin) : AW'(quad);
    assign e    = 6'($signed({1'b0, ex}) - EXP_BIAS);
    assign ep   = e * $signed({1'b0, lnq});

    always_comb begin
        n_side.last      = i_in.last_in;
        n_side.special   = 1'b1;
        n_side.spec_bits = HALF_QNAN;
        if (ex == '0 && man == '0) begin
            n_side.spec_bits = HALF_NEG_INF;
        end else if (!sgn && ex == EXP_ALL_ONES && man == '0) begin
            n_side.spec_bits = HALF_POS_INF;
        end else if (!sgn && ex != '0 && ex != EXP_ALL_ONES) begin
            n_side.special = 1'b0;
        end
    end

    logic [F-1:0]          r_t1, r_t2, r_t3;
    logic signed [S1W-1:0] r_s1;
    logic signed [S2W-1:0] r_s2;
    logic signed [S3W-1:0] r_s3;
    logic signed [AW-1:0]  r_alt1, r_alt2, r_alt3;
    logic signed [EW-1:0]  r_exp1, r_exp2, r_exp3;
    t_side                 r_side1, r_side2, r_side3, r_side4;
    logic signed [SW-1:0]  r_sum4;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_t1    <= t;
            r_s1    <= n_s1;
            r_alt1  <= n_alt;
            r_exp1  <= EW'(ep);
            r_side1 <= n_side;
        end
    end

    // stage 2
    logic signed [S1W+F:0] m2;
    logic signed [S2W-1:0] n_s2;

    assign m2   = r_s1 * $signed({1'b0, r_t1});
    assign n_s2 = S2W'(m2 >>> F) + S2W'(c2q);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_t2    <= r_t1;
            r_s2    <= n_s2;
            r_alt2  <= r_alt1;
            r_exp2  <= r_exp1;
            r_side2 <= r_side1;
        end
    end

    // stage 3
    logic signed [S2W+F:0] m3;
    logic signed [S3W-1:0] n_s3;

    assign m3   = r_s2 * $signed({1'b0, r_t2});
    assign n_s3 = S3W'(m3 >>> F) + S3W'(c1q);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_t3    <= r_t2;
            r_s3    <= n_s3;
            r_alt3  <= r_alt2;
            r_exp3  <= r_exp2;
            r_side3 <= r_side2;
        end
    end

    // stage 4: last Horner step or alternate polynomial, and exponent sum
    logic signed [S3W+F:0] m4;
    logic signed [SW-1:0]  poly;
    logic signed [SW-1:0]  n_sum;

    assign m4    = r_s3 * $signed({1'b0, r_t3});
    assign poly  = (is_quad || is_lin) ? SW'(r_alt3) : SW'(S3W'(m4 >>> F));
    assign n_sum = SW'(r_exp3) + poly;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_sum4  <= n_sum;
            r_side4 <= r_side3;
        end
    end

    hfnl_to_half #(
        .FRAC_BITS (FRAC_BITS)
    ) u_to_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld4),
        .i_sum   (r_sum4),
        .i_side  (r_side4),
        .o_stall (th_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out),
        .i_stall (i_out_stall)
    );

endmodule
`default_nettype wire

@@ rtl/hfnl_port_chk.sv @@
`default_nettype none
`include "half_float_natural_log_core_macros.svh"
module hfnl_port_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  hfnl_pkg::t_out_beat             o_out,
    input  logic                            i_out_stall
);
    import hfnl_pkg::*;

    `HFNL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "stalled beat dropped")
    `HFNL_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out), "stalled beat changed")
    `HFNL_ASSERT_NOW(a_in_stall_full, o_in_stall, o_out_valid && i_out_stall, "input stalled without a stalled output")
    `HFNL_ASSERT_RST(a_rst_empty, o_out_valid, "output valid right after reset")

endmodule

bind half_float_natural_log_core hfnl_port_chk u_port_chk (.*);
`default_nettype wire
